### src/hkst_pkg.sv
// Shared types and constants for the held key set tracker.
// Used by hkst_ctrl, hkst_dpath and held_key_set_tracker; depends on nothing.
package hkst_pkg;

    localparam int BYTE_W      = 8;
    localparam int KEY_W       = 7;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 5;
    localparam int RELEASE_BIT = 7;

    typedef enum logic [STATUS_W-1:0] {
        ST_IGNORED   = 3'd0,
        ST_ADDED     = 3'd1,
        ST_ALREADY   = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FULL      = 3'd5,
        ST_CLEARED   = 3'd6
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic    load;        // capture the input transfer
        logic    clr_total;   // empty the list
        logic    start;       // restart the search at entry 0
        logic    step;        // advance the search pointer
        logic    shift_start; // key found on release: begin moving entries down
        logic    shift_step;  // move one entry down
        logic    dec_total;   // drop one from the count
        logic    add;         // append the key at the end of the list
        logic    set_status;
        t_status status;
        logic    out_load;    // push the result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_clear;
        logic is_zero;
        logic is_release;
        logic hit;
        logic miss;
        logic full;
        logic shift_end;
        logic out_free;
    } t_stat;

endpackage

### src/hkst_ctrl.sv
// Sequencer for the held key set tracker: search, shift and result hand-off.
// Depends on hkst_pkg (t_cmd, t_stat, t_status).
module hkst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  hkst_pkg::t_stat i_stat,
    output hkst_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = hkst_pkg::ST_IGNORED;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.is_clear) begin
                    o_cmd.clr_total  = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = hkst_pkg::ST_CLEARED;
                    n_state          = S_DONE;
                end else if (i_stat.is_zero) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = hkst_pkg::ST_IGNORED;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_stat.hit) begin
                    if (i_stat.is_release) begin
                        o_cmd.shift_start = 1'b1;
                        n_state           = S_SHIFT;
                    end else begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = hkst_pkg::ST_ALREADY;
                        n_state          = S_DONE;
                    end
                end else if (i_stat.miss) begin
                    o_cmd.set_status = 1'b1;
                    n_state          = S_DONE;
                    if (i_stat.is_release) begin
                        o_cmd.status = hkst_pkg::ST_NOT_FOUND;
                    end else if (i_stat.full) begin
                        o_cmd.status = hkst_pkg::ST_FULL;
                    end else begin
                        o_cmd.add    = 1'b1;
                        o_cmd.status = hkst_pkg::ST_ADDED;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_end) begin
                    o_cmd.dec_total  = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = hkst_pkg::ST_REMOVED;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            S_DONE: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    no_step_outside_search : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> r_state == S_SEARCH)
        else $error("search step issued outside search");

    remove_after_shift : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.dec_total |-> $past(r_state) == S_SEARCH || $past(r_state) == S_SHIFT)
        else $error("count dropped without a prior search");

    one_result_per_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_state == S_IDLE && !o_cmd.out_load)
        else $error("result loaded twice");

endmodule

### src/hkst_dpath.sv
// Datapath for the held key set tracker: key list memory, pointers, count
// and output register. Depends on hkst_pkg; driven by hkst_ctrl commands.
module hkst_dpath #(
    parameter int MAX_HELD = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hkst_pkg::t_cmd               i_cmd,
    output hkst_pkg::t_stat              o_stat,
    input  logic                         i_op,
    input  logic [hkst_pkg::BYTE_W-1:0]  i_scan_byte,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [hkst_pkg::STATUS_W-1:0] o_status,
    output logic [hkst_pkg::KEY_W-1:0]   o_key_code,
    output logic [hkst_pkg::COUNT_W-1:0] o_held_count
);

    localparam int CW = $clog2(MAX_HELD + 1);
    localparam int AW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;

    logic [hkst_pkg::KEY_W-1:0]  mem [MAX_HELD];
    logic [hkst_pkg::KEY_W-1:0]  r_rd_data;

    logic                        r_op;
    logic [hkst_pkg::BYTE_W-1:0] r_byte;
    logic [CW-1:0]               r_idx;
    logic [CW-1:0]               n_idx;
    logic [CW-1:0]               r_wr_idx;
    logic [CW-1:0]               r_total;
    hkst_pkg::t_status           r_status;

    logic                        r_out_valid;
    logic [hkst_pkg::STATUS_W-1:0] r_out_status;
    logic [hkst_pkg::KEY_W-1:0]  r_out_key;
    logic [hkst_pkg::COUNT_W-1:0] r_out_count;

    logic [hkst_pkg::KEY_W-1:0]  key;

    assign key = r_byte[hkst_pkg::KEY_W-1:0];

    // Read address follows the next pointer, so r_rd_data holds mem[r_idx] while searching and shifting
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.start) begin
            n_idx = '0;
        end else if (i_cmd.step || i_cmd.shift_start || i_cmd.shift_step) begin
            n_idx = r_idx + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            mem[r_total[AW-1:0]] <= key;
        end
        if (i_cmd.shift_step) begin
            mem[r_wr_idx[AW-1:0]] <= r_rd_data;
        end
        r_rd_data <= mem[n_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_byte <= i_scan_byte;
        end
        // write pointer trails the read pointer by one during the shift
        if (i_cmd.shift_start || i_cmd.shift_step) begin
            r_wr_idx <= r_idx;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_key    <= (r_op || r_byte == '0) ? '0 : key;
            r_out_count  <= hkst_pkg::COUNT_W'(r_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_total) begin
                r_total <= '0;
            end else if (i_cmd.add) begin
                r_total <= r_total + CW'(1);
            end else if (i_cmd.dec_total) begin
                r_total <= r_total - CW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.is_clear   = r_op;
        o_stat.is_zero    = (r_byte == '0);
        o_stat.is_release = r_byte[hkst_pkg::RELEASE_BIT];
        o_stat.hit        = (r_idx < r_total) && (r_rd_data == key);
        o_stat.miss       = (r_idx >= r_total);
        o_stat.full       = (r_total >= CW'(MAX_HELD));
        o_stat.shift_end  = (r_idx >= r_total);
        o_stat.out_free   = !r_out_valid || i_ready;
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_key_code   = r_out_key;
    assign o_held_count = r_out_count;

    count_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(MAX_HELD))
        else $error("held count above capacity");

    no_add_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add |-> r_total < CW'(MAX_HELD))
        else $error("append into a full list");

    add_grows_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add |=> r_total == $past(r_total) + CW'(1))
        else $error("append did not grow the count");

    shift_write_behind_read : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift_step |-> (r_wr_idx + CW'(1) == r_idx) && (r_idx < r_total))
        else $error("shift pointers out of step");

endmodule

### src/held_key_set_tracker.sv
// Held key set tracker: keeps the ordered list of currently held key codes
// from raw scan bytes. Takes one transfer at a time. A clear or a zero byte
// goes from evaluation straight to the result. A press or a release first
// searches the list entry by entry; a release that finds its key then moves
// the later entries down one place to close the hole. The key list memory,
// with one read and one write port, is searched and compacted one entry per
// cycle. A finished result waits in the output register while the next item
// is accepted. The next result then holds the block until the first is taken.
// Depends on hkst_pkg, hkst_ctrl and hkst_dpath.
module held_key_set_tracker #(
    parameter int MAX_HELD = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [hkst_pkg::BYTE_W-1:0]   i_scan_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [hkst_pkg::STATUS_W-1:0] o_status,
    output logic [hkst_pkg::KEY_W-1:0]    o_key_code,
    output logic [hkst_pkg::COUNT_W-1:0]  o_held_count
);

    hkst_pkg::t_cmd  cmd;
    hkst_pkg::t_stat stat;

    hkst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    hkst_dpath #(
        .MAX_HELD (MAX_HELD)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_op         (i_op),
        .i_scan_byte  (i_scan_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_key_code   (o_key_code),
        .o_held_count (o_held_count)
    );

endmodule

### test/tb_held_key_set_tracker.sv
// Testbench for held_key_set_tracker: random and directed scan bytes, each result
// checked against a behavioral copy of the held key list kept in this file.
// Depends on hkst_pkg and held_key_set_tracker.
`timescale 1ns / 100ps

module tb_held_key_set_tracker;

    localparam int MAX_HELD       = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLDOFF_AT     = 500;
    localparam int HOLDOFF_LEN    = 300;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int POOL_SIZE      = 20;

    typedef struct packed {
        logic                        pause;   // wait for every pending result before moving on
        logic                        op;
        logic [hkst_pkg::BYTE_W-1:0] sb;
    } t_scan_item;

    typedef struct packed {
        hkst_pkg::t_status            status;
        logic [hkst_pkg::KEY_W-1:0]   key;
        logic [hkst_pkg::COUNT_W-1:0] count;
    } t_key_result;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic                          i_op        = 1'b0;
    logic [hkst_pkg::BYTE_W-1:0]   i_scan_byte = '0;
    logic                          i_ready     = 1'b0;
    logic                          o_ready;
    logic                          o_valid;
    logic [hkst_pkg::STATUS_W-1:0] o_status;
    logic [hkst_pkg::KEY_W-1:0]    o_key_code;
    logic [hkst_pkg::COUNT_W-1:0]  o_held_count;

    t_scan_item  pending_q[$];
    t_key_result expected_q[$];

    // Behavioral copy of the held list
    logic [hkst_pkg::KEY_W-1:0]   held_list[MAX_HELD];
    logic [hkst_pkg::COUNT_W-1:0] held_num = '0;

    int fail_count     = 0;
    int accepted_items = 0;
    int results_seen   = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int idle_cycles    = 0;

    held_key_set_tracker #(
        .MAX_HELD (MAX_HELD)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_scan_byte  (i_scan_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_key_code   (o_key_code),
        .o_held_count (o_held_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_key_result track_scan(input logic op,
                                               input logic [hkst_pkg::BYTE_W-1:0] sb);
        t_key_result                r;
        int                         pos;
        logic [hkst_pkg::KEY_W-1:0] code;
        code = sb[hkst_pkg::KEY_W-1:0];
        pos  = -1;
        if (op) begin
            held_num = '0;
            r.status = hkst_pkg::ST_CLEARED;
            code     = '0;
        end else if (sb == '0) begin
            r.status = hkst_pkg::ST_IGNORED;
            code     = '0;
        end else begin
            for (int i = 0; i < held_num; i++) begin
                if (pos < 0 && held_list[i] == code) pos = i;
            end
            if (sb[hkst_pkg::RELEASE_BIT]) begin
                if (pos >= 0) begin
                    // close the hole, keep order
                    for (int k = pos; k + 1 < held_num; k++) held_list[k] = held_list[k + 1];
                    held_num = held_num - 1'b1;
                    r.status = hkst_pkg::ST_REMOVED;
                end else begin
                    r.status = hkst_pkg::ST_NOT_FOUND;
                end
            end else if (pos >= 0) begin
                r.status = hkst_pkg::ST_ALREADY;
            end else if (held_num >= MAX_HELD) begin
                r.status = hkst_pkg::ST_FULL;
            end else begin
                held_list[held_num] = code;
                held_num = held_num + 1'b1;
                r.status = hkst_pkg::ST_ADDED;
            end
        end
        r.key   = code;
        r.count = held_num;
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_scan(input logic op, input logic [hkst_pkg::BYTE_W-1:0] sb);
        t_scan_item it;
        it.pause = 1'b0;
        it.op    = op;
        it.sb    = sb;
        pending_q.push_back(it);
    endtask

    task automatic push_pause();
        t_scan_item it;
        it = '0;
        it.pause = 1'b1;
        pending_q.push_back(it);
    endtask

    // Driver
    always @(posedge i_clk) begin : drive_proc
        t_scan_item nxt;
        logic       drive_valid;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_q.push_back(track_scan(i_op, i_scan_byte));
                accepted_items++;
            end
            // hold the payload while the transfer is still waiting
            if (!(i_valid && !o_ready)) begin
                drive_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() > 0) begin
                    if (pending_q[0].pause) begin
                        if (expected_q.size() == 0) void'(pending_q.pop_front());
                    end else begin
                        nxt = pending_q.pop_front();
                        i_op        <= nxt.op;
                        i_scan_byte <= nxt.sb;
                        drive_valid = 1'b1;
                        gap_left    = (accepted_items % 256 < 64) ? 0 : pick_gap();
                    end
                end
                i_valid <= drive_valid;
            end
        end
    end

    // Monitor and receiver
    always @(posedge i_clk) begin : monitor_proc
        t_key_result want;
        logic        take;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result with no transfer pending: status %0d key_code %0d held_count %0d",
                           o_status, o_key_code, o_held_count);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (o_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d", want.status, o_status);
                        fail_count++;
                    end
                    if (o_key_code !== want.key) begin
                        $error("key_code mismatch: expected %0d, actual %0d", want.key, o_key_code);
                        fail_count++;
                    end
                    if (o_held_count !== want.count) begin
                        $error("held_count mismatch: expected %0d, actual %0d",
                               want.count, o_held_count);
                        fail_count++;
                    end
                end
                results_seen++;
            end
            // one long hold-off so the block backs up and stalls its input
            if (!hold_done && results_seen >= HOLDOFF_AT) begin
                hold_done = 1'b1;
                hold_left = HOLDOFF_LEN;
            end
            take = 1'b0;
            if (hold_left > 0) begin
                hold_left--;
            end else if (stall_left > 0) begin
                stall_left--;
            end else begin
                take = 1'b1;
                if (results_seen % 256 >= 64 && $urandom_range(0, 2) == 0) stall_left = pick_gap();
            end
            i_ready <= take;
        end
    end

    // Watchdog: too long without any transfer on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin : stim_proc
        logic [hkst_pkg::KEY_W-1:0]  key_pool[POOL_SIZE];
        int                          counted;
        int                          kind;
        int                          len;
        int                          r;
        logic [hkst_pkg::KEY_W-1:0]  k;
        bit                          mid_pause;
        logic                        op;
        logic [hkst_pkg::BYTE_W-1:0] sb;

        // Directed: empty list cases, repeat press, fill to full, middle release
        push_scan(1'b0, 8'h00);
        push_scan(1'b0, 8'h80);
        push_scan(1'b0, 8'h01);
        push_scan(1'b0, 8'h01);
        push_scan(1'b0, 8'h7F);
        push_scan(1'b0, 8'hFF);
        push_scan(1'b0, 8'h81);
        for (int i = 0; i < MAX_HELD; i++) push_scan(1'b0, hkst_pkg::BYTE_W'(i * 8 + 1));
        push_scan(1'b0, 8'h7F);
        push_scan(1'b0, 8'h09);
        push_scan(1'b0, 8'hC1);
        push_scan(1'b0, 8'h00);
        push_scan(1'b1, 8'hFF);
        push_pause();

        counted   = 0;
        mid_pause = 1'b0;
        while (counted < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                // well-formed session over a pool a bit larger than the list
                for (int i = 0; i < POOL_SIZE; i++) begin
                    key_pool[i] = hkst_pkg::KEY_W'($urandom_range(1, 127));
                end
                len = $urandom_range(20, 60);
                for (int n = 0; n < len; n++) begin
                    r  = $urandom_range(0, 99);
                    k  = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                    op = 1'b0;
                    if (r < 55) sb = {1'b0, k};
                    else if (r < 95) sb = {1'b1, k};
                    else if (r < 97) sb = 8'h00;
                    else begin
                        op = 1'b1;
                        sb = hkst_pkg::BYTE_W'($urandom);
                    end
                    push_scan(op, sb);
                    if (op || sb != 8'h00) counted++;
                end
            end else if (kind <= 8) begin
                len = $urandom_range(10, 30);
                for (int n = 0; n < len; n++) begin
                    op = ($urandom_range(0, 7) == 0);
                    sb = hkst_pkg::BYTE_W'($urandom);
                    push_scan(op, sb);
                    if (op || sb != 8'h00) counted++;
                end
            end else begin
                // broken: repeated presses of one key, then releases of random keys
                k = hkst_pkg::KEY_W'($urandom_range(0, 127));
                len = $urandom_range(3, 8);
                for (int n = 0; n < len; n++) push_scan(1'b0, {1'b0, k});
                for (int n = 0; n < len; n++) begin
                    push_scan(1'b0, {1'b1, hkst_pkg::KEY_W'($urandom)});
                end
                counted += 2 * len;
            end
            if (!mid_pause && counted >= RANDOM_ITEMS / 2) begin
                mid_pause = 1'b1;
                push_pause();
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_q.size() != 0 || i_valid || expected_q.size() != 0);
        repeat (2 * MAX_HELD + 8) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
